FILE: hw/rtl/hcb_pkg.sv
// Package for the Huffman code builder: default sizes, field widths and the
// command and status structs between controller and datapath. No dependencies.
package hcb_pkg;

   localparam int MAX_LEAVES_DEF  = 16;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int IN_WEIGHT_W = 16;
   localparam int LEAF_IDX_W  = 4;
   localparam int CODE_W      = 15;
   localparam int CODE_LEN_W  = 4;

   // Commands from the controller to the datapath, one cycle each.
   typedef struct packed {
      logic load;         // store the incoming leaf weight
      logic start_build;  // latch leaf count, clear parent flags
      logic scan_start;   // restart the least-weight search
      logic scan_read;    // read node weight at the scan index
      logic scan_cmp;     // compare the read node against the two minima
      logic merge_a;      // write merged weight and first child's parent
      logic merge_b;      // write second child's parent, advance node index
      logic walk_start;   // start walking up from the current leaf
      logic walk_read;    // read the parent entry of the current node
      logic walk_up;      // take one code bit and move to the parent
      logic emit;         // capture the finished code into the result register
      logic next_leaf;    // advance to the next leaf
      logic finish;       // clear the leaf count for the next batch
   } hcb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic single;      // the batch being closed holds exactly one leaf
      logic scan_last;   // scan index is at the last node below the merge index
      logic merge_last;  // the current merge creates the root
      logic root;        // the node just read has no parent
      logic leaf_last;   // current leaf is the final one
   } hcb_stat_type;

endpackage

FILE: hw/rtl/huffman_code_builder.sv
// Top level of the Huffman code builder: joins the controller and datapath.
// Depends on hcb_pkg, hcb_ctrl and hcb_dpath.
//
//   channel  direction  ports                                           handshake
//   req      in         weight, last_weight                             valid / stall
//   rsp      out        leaf_index, code_bits, code_length, last_code   valid / stall
//
// Weights are taken one per cycle while the block is idle. The last weight starts
// the build: the merge that creates node k reads and compares nodes 0 .. k-1 in turn
// through the weight memory port, then writes the merged weight and both children's
// parent entries. Each leaf's walk reads the parent entry of every node on its path,
// root included, and then offers the result for transfer.
// Reset is synchronous and clears the leaf count, parent flags and controller.
// A stalled result holds; no weight is taken from the last weight until the final
// code's transfer.
module huffman_code_builder import hcb_pkg::*; #(
   parameter int MAX_LEAVES  = MAX_LEAVES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [IN_WEIGHT_W-1:0] req_weight,
   input  logic                   req_last_weight,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LEAF_IDX_W-1:0]  rsp_leaf_index,
   output logic [CODE_W-1:0]      rsp_code_bits,
   output logic [CODE_LEN_W-1:0]  rsp_code_length,
   output logic                   rsp_last_code
);

   hcb_cmd_type  cmd;
   hcb_stat_type stat;

   // Controller.
   hcb_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_weight (req_last_weight),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .leaf_last_hold  (rsp_last_code),
      .rsp_last_code   (rsp_last_code),
      .cmd             (cmd),
      .stat            (stat)
   );

   // Datapath.
   hcb_dpath #(
      .MAX_LEAVES  (MAX_LEAVES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_weight      (req_weight),
      .rsp_leaf_index  (rsp_leaf_index),
      .rsp_code_bits   (rsp_code_bits),
      .rsp_code_length (rsp_code_length)
   );

endmodule

FILE: hw/rtl/hcb_dpath.sv
// Datapath of the Huffman code builder: weight and parent memories, parent
// flags, search registers, walk registers and result register. Uses hcb_pkg.
module hcb_dpath import hcb_pkg::*; #(
   parameter int MAX_LEAVES  = MAX_LEAVES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hcb_cmd_type            cmd,
   output hcb_stat_type           stat,
   input  logic [IN_WEIGHT_W-1:0] req_weight,
   output logic [LEAF_IDX_W-1:0]  rsp_leaf_index,
   output logic [CODE_W-1:0]      rsp_code_bits,
   output logic [CODE_LEN_W-1:0]  rsp_code_length
);

   localparam int NODES = 2 * MAX_LEAVES - 1;
   localparam int NB    = $clog2(NODES);
   localparam int CB    = $clog2(MAX_LEAVES + 1);
   localparam int NWB   = WEIGHT_BITS + $clog2(MAX_LEAVES);

   // Memories: node weights, and parent index with the right-child bit.
   logic [NWB-1:0] wgt_mem [NODES];
   logic [NB:0]    par_mem [NODES];

   logic [CB-1:0]    cnt_ff, cnt_in;
   logic [CB-1:0]    n_ff;
   logic [NB-1:0]    last_k_ff;
   logic [NB-1:0]    k_ff, scan_ff, a_ff, b_ff, leaf_ff, node_ff, len_ff;
   logic [NWB-1:0]   wa_ff, wb_ff, rd_w_ff;
   logic             have_a_ff, have_b_ff, rd_pv_ff, root_ff;
   logic [NB:0]      rd_par_ff;
   logic [NODES-1:0] pv_ff;
   logic [CODE_W-1:0] code_ff;
   logic [CB-1:0]    n_next;
   logic [WEIGHT_BITS-1:0] load_w;

   assign n_next = (cnt_ff < CB'(MAX_LEAVES)) ? CB'(cnt_ff + 1'b1) : cnt_ff;
   assign load_w = WEIGHT_BITS'(32'(req_weight));

   assign stat.single     = (n_next == CB'(1));
   assign stat.scan_last  = (scan_ff == NB'(k_ff - 1'b1));
   assign stat.merge_last = (k_ff == last_k_ff);
   assign stat.root       = root_ff;
   assign stat.leaf_last  = (CB'(leaf_ff) + 1'b1 == n_ff);

   // Weight memory: leaves on load, merged nodes on the first merge cycle.
   always_ff @(posedge clock) begin
      if (cmd.load && cnt_ff < CB'(MAX_LEAVES)) begin
         wgt_mem[NB'(cnt_ff)] <= NWB'(load_w);
      end else if (cmd.merge_a) begin
         wgt_mem[k_ff] <= NWB'(wa_ff + wb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         rd_w_ff <= wgt_mem[scan_ff];
      end
   end

   // Parent memory: one child per merge cycle.
   always_ff @(posedge clock) begin
      if (cmd.merge_a) begin
         par_mem[a_ff] <= {k_ff, 1'b0};
      end else if (cmd.merge_b) begin
         par_mem[b_ff] <= {k_ff, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_read) begin
         rd_par_ff <= par_mem[node_ff];
      end
   end

   // Leaf count and parent flags.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.finish) begin
         cnt_in = '0;
      end else if (cmd.load) begin
         cnt_in = n_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pv_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.start_build) begin
            pv_ff <= '0;
         end else if (cmd.merge_a) begin
            pv_ff[a_ff] <= 1'b1;
         end else if (cmd.merge_b) begin
            pv_ff[b_ff] <= 1'b1;
         end
      end
   end

   // Build control registers and the least-weight search.
   always_ff @(posedge clock) begin
      if (cmd.start_build) begin
         n_ff      <= n_next;
         k_ff      <= NB'(n_next);
         last_k_ff <= NB'({n_next, 1'b0} - 2'd2);
         leaf_ff   <= '0;
      end
      if (cmd.scan_start) begin
         scan_ff   <= '0;
         have_a_ff <= 1'b0;
         have_b_ff <= 1'b0;
      end
      if (cmd.scan_read) begin
         rd_pv_ff <= pv_ff[scan_ff];
      end
      if (cmd.scan_cmp) begin
         scan_ff <= NB'(scan_ff + 1'b1);
         if (!rd_pv_ff) begin
            if (!have_a_ff || rd_w_ff < wa_ff) begin
               if (have_a_ff) begin
                  b_ff      <= a_ff;
                  wb_ff     <= wa_ff;
                  have_b_ff <= 1'b1;
               end
               a_ff      <= scan_ff;
               wa_ff     <= rd_w_ff;
               have_a_ff <= 1'b1;
            end else if (!have_b_ff || rd_w_ff < wb_ff) begin
               b_ff      <= scan_ff;
               wb_ff     <= rd_w_ff;
               have_b_ff <= 1'b1;
            end
         end
      end
      if (cmd.merge_b) begin
         k_ff <= NB'(k_ff + 1'b1);
      end
      if (cmd.next_leaf) begin
         leaf_ff <= NB'(leaf_ff + 1'b1);
      end
   end

   // Walk from the leaf to the root, collecting one bit per level.
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         node_ff <= cmd.next_leaf ? NB'(leaf_ff + 1'b1) :
                    (cmd.start_build ? '0 : leaf_ff);
         code_ff <= '0;
         len_ff  <= '0;
      end
      if (cmd.walk_read) begin
         root_ff <= !pv_ff[node_ff];
      end
      if (cmd.walk_up) begin
         if (rd_par_ff[0]) begin
            code_ff <= code_ff | (CODE_W'(1) << len_ff);
         end
         len_ff  <= NB'(len_ff + 1'b1);
         node_ff <= rd_par_ff[NB:1];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_leaf_index  <= LEAF_IDX_W'(leaf_ff);
         rsp_code_bits   <= code_ff;
         rsp_code_length <= CODE_LEN_W'(len_ff);
      end
   end

endmodule

FILE: hw/rtl/hcb_ctrl.sv
// Controller of the Huffman code builder: sequences load, search, merge, walk
// and result transfer. Uses hcb_pkg for the command and status structs.
module hcb_ctrl import hcb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last_weight,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         leaf_last_hold,
   output logic         rsp_last_code,
   output hcb_cmd_type  cmd,
   input  hcb_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_MERGE_A, S_MERGE_B, S_WALK_RD, S_WALK_UP, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      last_ff, last_in;

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_last_code = last_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_weight) begin
                  cmd.start_build = 1'b1;
                  if (stat.single) begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK_RD;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = stat.scan_last ? S_MERGE_A : S_SCAN_RD;
         end
         S_MERGE_A: begin
            cmd.merge_a = 1'b1;
            state_in    = S_MERGE_B;
         end
         S_MERGE_B: begin
            cmd.merge_b = 1'b1;
            if (stat.merge_last) begin
               cmd.walk_start = 1'b1;
               state_in       = S_WALK_RD;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN_RD;
            end
         end
         S_WALK_RD: begin
            cmd.walk_read = 1'b1;
            state_in      = S_WALK_UP;
         end
         S_WALK_UP: begin
            if (stat.root) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               last_in  = stat.leaf_last;
               state_in = S_EMIT;
            end else begin
               cmd.walk_up = 1'b1;
               state_in    = S_WALK_RD;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (leaf_last_hold) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.next_leaf  = 1'b1;
                  cmd.walk_start = 1'b1;
                  state_in       = S_WALK_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

endmodule

FILE: hw/rtl/hcb_checker.sv
// Port checker for the Huffman code builder, bound to the top level.
// Depends only on the top level's ports.
module hcb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_weight,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_leaf_index,
   input logic [14:0] rsp_code_bits,
   input logic [3:0]  rsp_code_length,
   input logic        rsp_last_code
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_leaf_index) &&
      $stable(rsp_code_bits) && $stable(rsp_code_length) && $stable(rsp_last_code))
      else $error("stalled result changed");

   // No weight is taken while a result is offered.
   a_no_load_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // The final weight starts the build, which closes the input.
   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_weight |=> req_stall)
      else $error("input open after final weight");

   // The final code's transfer ends the batch.
   a_batch_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_code |=> !rsp_valid)
      else $error("result after final code");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_last_weight (req_last_weight),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_leaf_index  (rsp_leaf_index),
   .rsp_code_bits   (rsp_code_bits),
   .rsp_code_length (rsp_code_length),
   .rsp_last_code   (rsp_last_code)
);
